FILE: design/pwmts_pkg.sv
package pwmts_pkg;

   localparam int CFG_W      = 36;
   localparam int FREQ_W     = 40;
   localparam int DUTY_W     = 10;
   localparam int PRE_W      = 21;
   localparam int PER_W      = 17;
   localparam int PULSE_W    = 16;
   localparam int AFREQ_W    = 36;
   localparam int ADUTY_W    = 10;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 104;

   localparam int DIV_W      = 37;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int PROD_W     = 27;

   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FMAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FMIN  = 2'd2;

   localparam logic [CFG_W-1:0] CLOCK_RESET = 36'd48000000000;
   localparam logic [CFG_W-1:0] FMAX_RESET  = 36'd12000000000;
   localparam logic [CFG_W-1:0] FMIN_RESET  = 36'd12;

   localparam logic [DIV_W-1:0]  PERIOD_LIMIT = 37'd65536;
   localparam logic [DUTY_W-1:0] DUTY_FULL    = 10'd1000;

   typedef struct packed {
      logic [CFG_W-1:0] clock_mhz;
      logic [CFG_W-1:0] fmax;
      logic [CFG_W-1:0] fmin;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [PRE_W-1:0]   prescale_factor;
      logic [PER_W-1:0]   period_count;
      logic [PULSE_W-1:0] pulse_count;
      logic [AFREQ_W-1:0] actual_freq;
      logic [ADUTY_W-1:0] actual_duty;
   } result_type;

endpackage

FILE: design/pwmts_csr.sv
module pwmts_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pwmts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwmts_pkg::CFG_W-1:0]          csr_wdata,
   output pwmts_pkg::cfg_type                   cfg
);

   pwmts_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pwmts_pkg::CSR_CLOCK: cfg_in.clock_mhz = csr_wdata;
            pwmts_pkg::CSR_FMAX:  cfg_in.fmax      = csr_wdata;
            pwmts_pkg::CSR_FMIN:  cfg_in.fmin      = csr_wdata;
            default:              cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_mhz <= pwmts_pkg::CLOCK_RESET;
         cfg_ff.fmax      <= pwmts_pkg::FMAX_RESET;
         cfg_ff.fmin      <= pwmts_pkg::FMIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pwmts_div.sv
module pwmts_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pwmts_pkg::div_req_type div_req,
   output pwmts_pkg::div_rsp_type div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pwmts_pkg::DIV_CNT_W-1:0]   step_ff, step_in;
   logic [pwmts_pkg::DIV_W-1:0]       rem_ff, rem_in;
   logic [pwmts_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [pwmts_pkg::DIV_W-1:0]       dvs_ff, dvs_in;
   logic [pwmts_pkg::DIV_W:0]         trial_rem;
   logic [pwmts_pkg::DIV_W:0]         diff;

   // Restoring division: the dividend shifts out of the top of the quotient
   // register while quotient bits shift in at the bottom, one bit per cycle.
   always_comb begin
      trial_rem = {rem_ff, quo_ff[pwmts_pkg::DIV_W-1]};
      diff      = trial_rem - {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[pwmts_pkg::DIV_W]) begin
            rem_in = diff[pwmts_pkg::DIV_W-1:0];
            quo_in = {quo_ff[pwmts_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial_rem[pwmts_pkg::DIV_W-1:0];
            quo_in = {quo_ff[pwmts_pkg::DIV_W-2:0], 1'b0};
         end
         step_in = step_ff + pwmts_pkg::DIV_CNT_W'(1);
         if (step_ff == pwmts_pkg::DIV_CNT_W'(pwmts_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: design/pwmts_seq.sv
module pwmts_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pwmts_pkg::FREQ_W-1:0]    req_freq,
   input  logic [pwmts_pkg::DUTY_W-1:0]    req_duty,
   input  pwmts_pkg::cfg_type              cfg,
   output pwmts_pkg::div_req_type          div_req,
   input  pwmts_pkg::div_rsp_type          div_rsp,
   input  logic                            out_free,
   output logic                            res_load,
   output pwmts_pkg::result_type           result
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_CLAMP_MAX  = 4'd1;
   localparam logic [3:0] S_CLAMP_MIN  = 4'd2;
   localparam logic [3:0] S_CNT_GO     = 4'd3;
   localparam logic [3:0] S_CNT_WAIT   = 4'd4;
   localparam logic [3:0] S_NORM       = 4'd5;
   localparam logic [3:0] S_FREQ_GO    = 4'd6;
   localparam logic [3:0] S_FREQ_WAIT  = 4'd7;
   localparam logic [3:0] S_PULSE_GO   = 4'd8;
   localparam logic [3:0] S_PULSE_WAIT = 4'd9;
   localparam logic [3:0] S_DUTY_GO    = 4'd10;
   localparam logic [3:0] S_DUTY_WAIT  = 4'd11;
   localparam logic [3:0] S_DONE       = 4'd12;

   logic [3:0]                        state_ff, state_in;
   logic [pwmts_pkg::FREQ_W-1:0]      freq_ff, freq_in;
   logic [pwmts_pkg::DUTY_W-1:0]      duty_ff, duty_in;
   logic [pwmts_pkg::DIV_W-1:0]       cnt_ff, cnt_in;
   logic [pwmts_pkg::PRE_W-1:0]       pre_ff, pre_in;
   logic [pwmts_pkg::CFG_W-1:0]       clk_sh_ff, clk_sh_in;
   logic [pwmts_pkg::AFREQ_W-1:0]     afreq_ff, afreq_in;
   logic [pwmts_pkg::PER_W-1:0]       pulse_ff, pulse_in;
   logic [pwmts_pkg::ADUTY_W-1:0]     aduty_ff, aduty_in;
   logic [pwmts_pkg::FREQ_W-1:0]      freq_min;
   logic [pwmts_pkg::PER_W-1:0]       pulse_raw;
   logic [pwmts_pkg::PER_W-1:0]       pulse_dec;
   logic [pwmts_pkg::PROD_W-1:0]      pulse_prod;
   logic [pwmts_pkg::PROD_W-1:0]      duty_prod;

   assign pulse_prod = pwmts_pkg::PROD_W'(cnt_ff[pwmts_pkg::PER_W-1:0])
                     * pwmts_pkg::PROD_W'(duty_ff);
   assign duty_prod  = pwmts_pkg::PROD_W'(pulse_ff)
                     * pwmts_pkg::PROD_W'(pwmts_pkg::DUTY_FULL);

   always_comb begin
      state_in  = state_ff;
      freq_in   = freq_ff;
      duty_in   = duty_ff;
      cnt_in    = cnt_ff;
      pre_in    = pre_ff;
      clk_sh_in = clk_sh_ff;
      afreq_in  = afreq_ff;
      pulse_in  = pulse_ff;
      aduty_in  = aduty_ff;
      div_req   = '0;
      freq_min  = freq_ff;
      pulse_raw = div_rsp.quotient[pwmts_pkg::PER_W-1:0];
      pulse_dec = pulse_raw;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               freq_in = req_freq;
               if (req_duty == '0) begin
                  duty_in = pwmts_pkg::DUTY_W'(1);
               end else if (req_duty > pwmts_pkg::DUTY_FULL) begin
                  duty_in = pwmts_pkg::DUTY_FULL;
               end else begin
                  duty_in = req_duty;
               end
               state_in = S_CLAMP_MAX;
            end
         end
         S_CLAMP_MAX: begin
            if (freq_ff > pwmts_pkg::FREQ_W'(cfg.fmax)) begin
               freq_in = pwmts_pkg::FREQ_W'(cfg.fmax);
            end
            state_in = S_CLAMP_MIN;
         end
         S_CLAMP_MIN: begin
            if (freq_ff < pwmts_pkg::FREQ_W'(cfg.fmin)) begin
               freq_min = pwmts_pkg::FREQ_W'(cfg.fmin);
            end
            if (freq_min == '0) begin
               freq_in = pwmts_pkg::FREQ_W'(1);
            end else begin
               freq_in = freq_min;
            end
            state_in = S_CNT_GO;
         end
         S_CNT_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = pwmts_pkg::DIV_W'(cfg.clock_mhz)
                             + pwmts_pkg::DIV_W'(freq_ff >> 1);
            div_req.divisor  = pwmts_pkg::DIV_W'(freq_ff);
            pre_in           = pwmts_pkg::PRE_W'(1);
            clk_sh_in        = cfg.clock_mhz;
            state_in         = S_CNT_WAIT;
         end
         S_CNT_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  cnt_in = pwmts_pkg::DIV_W'(1);
               end else begin
                  cnt_in = div_rsp.quotient;
               end
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (cnt_ff > pwmts_pkg::PERIOD_LIMIT) begin
               cnt_in    = cnt_ff >> 1;
               pre_in    = pre_ff << 1;
               clk_sh_in = clk_sh_ff >> 1;
            end else begin
               state_in = S_FREQ_GO;
            end
         end
         S_FREQ_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = pwmts_pkg::DIV_W'(clk_sh_ff);
            div_req.divisor  = cnt_ff;
            state_in         = S_FREQ_WAIT;
         end
         S_FREQ_WAIT: begin
            if (div_rsp.done) begin
               afreq_in = div_rsp.quotient[pwmts_pkg::AFREQ_W-1:0];
               state_in = S_PULSE_GO;
            end
         end
         S_PULSE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = pwmts_pkg::DIV_W'(pulse_prod);
            div_req.divisor  = pwmts_pkg::DIV_W'(pwmts_pkg::DUTY_FULL);
            state_in         = S_PULSE_WAIT;
         end
         S_PULSE_WAIT: begin
            if (div_rsp.done) begin
               if (pulse_raw == cnt_ff[pwmts_pkg::PER_W-1:0]) begin
                  pulse_dec = pulse_raw - pwmts_pkg::PER_W'(1);
               end
               if (pulse_dec == pwmts_pkg::PER_W'(1)) begin
                  pulse_in = pwmts_pkg::PER_W'(2);
               end else begin
                  pulse_in = pulse_dec;
               end
               state_in = S_DUTY_GO;
            end
         end
         S_DUTY_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = pwmts_pkg::DIV_W'(duty_prod);
            div_req.divisor  = cnt_ff;
            state_in         = S_DUTY_WAIT;
         end
         S_DUTY_WAIT: begin
            if (div_rsp.done) begin
               aduty_in = div_rsp.quotient[pwmts_pkg::ADUTY_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff   <= freq_in;
      duty_ff   <= duty_in;
      cnt_ff    <= cnt_in;
      pre_ff    <= pre_in;
      clk_sh_ff <= clk_sh_in;
      afreq_ff  <= afreq_in;
      pulse_ff  <= pulse_in;
      aduty_ff  <= aduty_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_load  = (state_ff == S_DONE) && out_free;

   assign result.prescale_factor = pre_ff;
   assign result.period_count    = cnt_ff[pwmts_pkg::PER_W-1:0];
   assign result.pulse_count     = pulse_ff[pwmts_pkg::PULSE_W-1:0];
   assign result.actual_freq     = afreq_ff;
   assign result.actual_duty     = aduty_ff;

endmodule

FILE: design/pwm_timer_setting_solver_top.sv
// Turns a requested PWM frequency (millihertz) and duty (tenths of a percent) into
// a power-of-two prescaler, a period count and a pulse count, and reports the
// frequency and duty that these settings achieve. One item is handled at a time,
// using four divisions on one shared bit-serial divider that yields 37 quotient
// bits, up to 20 single-bit prescaler shifts, and the control states between
// them. A finished result waits in the output register, so the next beat is
// accepted while the previous result has not yet been taken. Configuration is
// to be written through the csr_ port while the block is idle; the user is bound
// by this, and the block itself does not enforce it.
module pwm_timer_setting_solver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // requested_freq[39:0], requested_duty[49:40], zero fill above.
   input  logic [pwmts_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // prescale_factor[20:0], period_count[37:21], pulse_count[53:38],
   // actual_freq[89:54], actual_duty[99:90], zero fill above.
   output logic [pwmts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [pwmts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwmts_pkg::CFG_W-1:0]          csr_wdata
);

   pwmts_pkg::cfg_type      cfg;
   pwmts_pkg::div_req_type  div_req;
   pwmts_pkg::div_rsp_type  div_rsp;
   pwmts_pkg::result_type   result;
   pwmts_pkg::result_type   rsp_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;
   logic                    res_load;

   pwmts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwmts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pwmts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_freq  (req_tdata[pwmts_pkg::FREQ_W-1:0]),
      .req_duty  (req_tdata[pwmts_pkg::FREQ_W +: pwmts_pkg::DUTY_W]),
      .cfg       (cfg),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .out_free  (out_free),
      .res_load  (res_load),
      .result    (result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.actual_duty,
                        rsp_data_ff.actual_freq,
                        rsp_data_ff.pulse_count,
                        rsp_data_ff.period_count,
                        rsp_data_ff.prescale_factor};

`ifndef SYNTHESIS
   a_pulse_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff.pulse_count} <= rsp_data_ff.period_count))
      else $error("pulse count exceeds period count");

   a_prescale_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_data_ff.prescale_factor))
      else $error("prescale factor is not a power of two");

   a_period_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.period_count != '0 &&
         pwmts_pkg::DIV_W'(rsp_data_ff.period_count) <= pwmts_pkg::PERIOD_LIMIT))
      else $error("period count out of range");

   a_div_no_early_done: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.done)
      else $error("divider finished right after start");
`endif

endmodule
